FILE: rtl/clbe_pkg.sv
package clbe_pkg;

  // buffer geometry
  localparam int DEPTH  = 256;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CHAR_W = 8;
  localparam int REQ_W  = 4;
  localparam int IDX_W  = 8;

  // request codes
  localparam logic [REQ_W-1:0] REQ_TYPE  = 4'd0;
  localparam logic [REQ_W-1:0] REQ_BKSP  = 4'd1;
  localparam logic [REQ_W-1:0] REQ_DALL  = 4'd2;
  localparam logic [REQ_W-1:0] REQ_LEFT  = 4'd3;
  localparam logic [REQ_W-1:0] REQ_RIGHT = 4'd4;
  localparam logic [REQ_W-1:0] REQ_HOME  = 4'd5;
  localparam logic [REQ_W-1:0] REQ_END   = 4'd6;
  localparam logic [REQ_W-1:0] REQ_READ  = 4'd7;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 4'd8;

endpackage

FILE: rtl/cursor_line_edit_buffer_unit.sv
// line edit buffer with a cursor. a request is taken when start is high and busy is
// low; its status (read_char, cursor_pos, text_length, refused) is shown for exactly
// one cycle with done high, starting the cycle after the request finishes, and the
// receiver cannot hold it off. cursor moves, home, end, clear and unused codes answer
// in the cycle after acceptance and keep busy low, so one can be taken every cycle. a
// read waits in S_READ for one synchronous memory read. type, backspace and delete-all
// move text through the single-port-pair text memory one byte per cycle, pipelined
// read-then-write, and stay busy until the last byte is written; the status appears in
// the same cycle that busy drops. a refused type, a backspace at position zero and a
// delete-all on an empty buffer answer like a cursor move. the text memory is not
// cleared at reset; a read at or past the length returns zero. type is refused
// once the buffer holds DEPTH-1 bytes.
module cursor_line_edit_buffer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [clbe_pkg::REQ_W-1:0]    req_type,
  input  logic [clbe_pkg::CHAR_W-1:0]   char_code,
  input  logic [clbe_pkg::IDX_W-1:0]    read_index,
  output logic                          done,
  output logic [clbe_pkg::CHAR_W-1:0]   read_char,
  output logic [7:0]                    cursor_pos,
  output logic [7:0]                    text_length,
  output logic                          refused
);

  localparam int AW = clbe_pkg::ADDR_W;
  localparam int CW = clbe_pkg::CHAR_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1; // shift tail right, then drop the new byte in
  localparam logic [2:0] S_BKSP = 3'd2; // shift tail left over the removed byte
  localparam logic [2:0] S_DALL = 3'd3; // compact, skipping every match
  localparam logic [2:0] S_READ = 3'd4; // wait for the memory read

  logic [2:0]    state, state_next;
  logic [AW-1:0] fill, fill_next;       // bytes held
  logic [AW-1:0] cursor, cursor_next;
  logic [AW-1:0] ptr, ptr_next;         // next address to read
  logic          more, more_next;       // reads still to issue
  logic          pend, pend_next;       // read data arriving this cycle
  logic [AW-1:0] pend_addr, pend_addr_next;
  logic [AW-1:0] wr, wr_next;           // delete-all write pointer
  logic [AW-1:0] left_hits, left_hits_next; // matches found left of the cursor
  logic [CW-1:0] ch, ch_next;           // byte of the running request
  logic          hit, hit_next;         // read index lies inside the text
  logic          done_next;
  logic [CW-1:0] read_char_next;
  logic          refused_next;

  // text memory port signals
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [CW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [CW-1:0] mem_rdata;

  clbe_ram #(
    .WIDTH (CW),
    .DEPTH (clbe_pkg::DEPTH)
  ) u_text_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_comb begin
    state_next     = state;
    fill_next      = fill;
    cursor_next    = cursor;
    ptr_next       = ptr;
    more_next      = more;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    wr_next        = wr;
    left_hits_next = left_hits;
    ch_next        = ch;
    hit_next       = hit;
    done_next      = 1'b0;
    read_char_next = '0;
    refused_next   = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = pend_addr;
    mem_wdata      = mem_rdata;
    mem_raddr      = ptr;

    unique case (state)
      S_IDLE: begin
        // the read address is presented directly so the data is ready in S_READ
        mem_raddr = AW'(read_index);
        if (start) begin
          case (req_type)
            clbe_pkg::REQ_TYPE: begin
              if (fill == AW'(clbe_pkg::DEPTH - 1)) begin
                refused_next = 1'b1;
                done_next    = 1'b1;
              end else begin
                state_next = S_INS;
                ptr_next   = fill - AW'(1);
                more_next  = (fill != cursor);
                pend_next  = 1'b0;
                ch_next    = char_code;
              end
            end
            clbe_pkg::REQ_BKSP: begin
              if (cursor != '0) begin
                state_next = S_BKSP;
                ptr_next   = cursor;
                more_next  = (cursor != fill);
                pend_next  = 1'b0;
              end else begin
                done_next = 1'b1;
              end
            end
            clbe_pkg::REQ_DALL: begin
              if (fill != '0) begin
                state_next     = S_DALL;
                ptr_next       = '0;
                more_next      = 1'b1;
                pend_next      = 1'b0;
                wr_next        = '0;
                left_hits_next = '0;
                ch_next        = char_code;
              end else begin
                done_next = 1'b1;
              end
            end
            clbe_pkg::REQ_LEFT: begin
              if (cursor != '0) begin
                cursor_next = cursor - AW'(1);
              end
              done_next = 1'b1;
            end
            clbe_pkg::REQ_RIGHT: begin
              if (cursor != fill) begin
                cursor_next = cursor + AW'(1);
              end
              done_next = 1'b1;
            end
            clbe_pkg::REQ_HOME: begin
              cursor_next = '0;
              done_next   = 1'b1;
            end
            clbe_pkg::REQ_END: begin
              cursor_next = fill;
              done_next   = 1'b1;
            end
            clbe_pkg::REQ_READ: begin
              state_next = S_READ;
              hit_next   = (32'(read_index) < 32'(fill));
            end
            clbe_pkg::REQ_CLEAR: begin
              fill_next   = '0;
              cursor_next = '0;
              done_next   = 1'b1;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      S_INS: begin
        // byte read last cycle lands one place to the right
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr + AW'(1);
        end
        pend_next      = more;
        pend_addr_next = ptr;
        if (more) begin
          ptr_next  = ptr - AW'(1);
          more_next = (ptr != cursor);
        end else if (!pend) begin
          mem_we      = 1'b1;
          mem_waddr   = cursor;
          mem_wdata   = ch;
          fill_next   = fill + AW'(1);
          cursor_next = cursor + AW'(1);
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end
      end

      S_BKSP: begin
        // byte read last cycle lands one place to the left
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr - AW'(1);
        end
        pend_next      = more;
        pend_addr_next = ptr;
        if (more) begin
          ptr_next  = ptr + AW'(1);
          more_next = ((ptr + AW'(1)) != fill);
        end else if (!pend) begin
          fill_next   = fill - AW'(1);
          cursor_next = cursor - AW'(1);
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end
      end

      S_DALL: begin
        // writes trail reads, so no write hits an address still to be read
        mem_waddr = wr;
        if (pend) begin
          if (mem_rdata != ch) begin
            mem_we  = 1'b1;
            wr_next = wr + AW'(1);
          end else if (pend_addr < cursor) begin
            left_hits_next = left_hits + AW'(1);
          end
        end
        pend_next      = more;
        pend_addr_next = ptr;
        if (more) begin
          ptr_next  = ptr + AW'(1);
          more_next = ((ptr + AW'(1)) != fill);
        end else if (!pend) begin
          fill_next   = wr;
          cursor_next = cursor - left_hits;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end
      end

      S_READ: begin
        read_char_next = hit ? mem_rdata : '0;
        done_next      = 1'b1;
        state_next     = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      fill   <= '0;
      cursor <= '0;
      more   <= 1'b0;
      pend   <= 1'b0;
      done   <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      cursor <= cursor_next;
      more   <= more_next;
      pend   <= pend_next;
      done   <= done_next;
    end
    ptr       <= ptr_next;
    pend_addr <= pend_addr_next;
    wr        <= wr_next;
    left_hits <= left_hits_next;
    ch        <= ch_next;
    hit       <= hit_next;
    read_char <= read_char_next;
    refused   <= refused_next;
  end

  // status ports
  assign busy        = (state != S_IDLE);
  assign cursor_pos  = 8'(cursor);
  assign text_length = 8'(fill);

endmodule

FILE: rtl/clbe_ram.sv
module clbe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/clbe_checker.sv
module clbe_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [clbe_pkg::REQ_W-1:0] req_type,
  input logic                       done,
  input logic [7:0]                 cursor_pos,
  input logic [7:0]                 text_length,
  input logic                       refused
);

  // left and home cursor moves answer in the next cycle
  a_move_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == clbe_pkg::REQ_LEFT || req_type == clbe_pkg::REQ_HOME))
      |=> done)
    else $error("cursor move not answered next cycle");

  // cursor never passes the end of text
  a_cursor_in_text: assert property (@(posedge clk) disable iff (rst)
    done |-> (cursor_pos <= text_length))
    else $error("cursor beyond text length");

  // refusal only with a full buffer
  a_refuse_full: assert property (@(posedge clk) disable iff (rst)
    refused |-> (done && text_length == 8'(clbe_pkg::DEPTH - 1)))
    else $error("refusal without full buffer");

  // a long request ends with its status
  a_busy_end: assert property (@(posedge clk) disable iff (rst)
    ($fell(busy) && !$past(rst)) |-> done)
    else $error("busy dropped without status");

endmodule

bind cursor_line_edit_buffer_unit clbe_checker u_clbe_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .req_type    (req_type),
  .done        (done),
  .cursor_pos  (cursor_pos),
  .text_length (text_length),
  .refused     (refused)
);

FILE: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import clbe_pkg::*;

  // stimulus stops after this many requests; timeout in clock cycles
  localparam int N_REQUESTS  = 1550;
  localparam int CYCLE_LIMIT = 2_000_000;

  // status of one request as shown on the result ports
  typedef struct packed {
    logic [CHAR_W-1:0] rchar;
    logic [7:0]        cpos;
    logic [7:0]        len;
    logic              refused;
  } status_t;

  // directed stimulus row; fixed rows carry a hand-written status
  typedef struct {
    logic [REQ_W-1:0]  rq;
    logic [CHAR_W-1:0] cc;
    logic [IDX_W-1:0]  ix;
    bit                fixed;
    status_t           want;
  } row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [REQ_W-1:0]  req_type = '0;
  logic [CHAR_W-1:0] char_code = '0;
  logic [IDX_W-1:0]  read_index = '0;
  logic              done;
  logic [CHAR_W-1:0] read_char;
  logic [7:0]        cursor_pos;
  logic [7:0]        text_length;
  logic              refused;

  // predictor state: text bytes, length and cursor
  logic [CHAR_W-1:0] line_text [DEPTH];
  int                line_len = 0;
  int                line_cur = 0;

  // statuses still owed by the block, oldest first
  status_t pending_status[$];
  int      mismatch_cnt = 0;
  int      n_sent = 0;
  int      burst_left = 0;

  always #5 clk = ~clk;

  cursor_line_edit_buffer_unit i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req_type    (req_type),
    .char_code   (char_code),
    .read_index  (read_index),
    .done        (done),
    .read_char   (read_char),
    .cursor_pos  (cursor_pos),
    .text_length (text_length),
    .refused     (refused)
  );

  // apply one request to the predictor and return the status it should report
  function automatic status_t edit_line(logic [REQ_W-1:0] rq, logic [CHAR_W-1:0] cc,
                                        logic [IDX_W-1:0] ix);
    status_t s;
    int      wr;
    int      gone_left;
    s = '0;
    case (rq)
      REQ_TYPE: begin
        // one slot always stays free, so a buffer at DEPTH-1 refuses
        if (line_len + 1 >= DEPTH) begin
          s.refused = 1'b1;
        end else begin
          for (int i = line_len; i > line_cur; i--) line_text[i] = line_text[i-1];
          line_text[line_cur] = cc;
          line_len++;
          line_cur++;
        end
      end
      REQ_BKSP: begin
        if (line_cur > 0) begin
          for (int i = line_cur; i < line_len; i++) line_text[i-1] = line_text[i];
          line_len--;
          line_cur--;
        end
      end
      REQ_DALL: begin
        // compact in place; every match left of the cursor pulls it back by one
        wr = 0;
        gone_left = 0;
        for (int rd = 0; rd < line_len; rd++) begin
          if (line_text[rd] == cc) begin
            if (rd < line_cur) gone_left++;
          end else begin
            line_text[wr] = line_text[rd];
            wr++;
          end
        end
        line_len = wr;
        line_cur -= gone_left;
      end
      REQ_LEFT:  if (line_cur > 0) line_cur--;
      REQ_RIGHT: if (line_cur < line_len) line_cur++;
      REQ_HOME:  line_cur = 0;
      REQ_END:   line_cur = line_len;
      REQ_READ:  if (int'(ix) < line_len) s.rchar = line_text[ix];
      REQ_CLEAR: begin
        line_len = 0;
        line_cur = 0;
      end
      default: ;  // unused codes leave everything alone
    endcase
    s.cpos = line_cur[7:0];
    s.len  = line_len[7:0];
    return s;
  endfunction

  // sender pacing: bursts of random length, random gaps, now and then a long burst
  task automatic pace();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  // drive one request, hold it until the block takes it, then record the status owed
  task automatic issue(logic [REQ_W-1:0] rq, logic [CHAR_W-1:0] cc, logic [IDX_W-1:0] ix,
                       bit fixed = 1'b0, status_t want = '0);
    status_t s;
    req_type   <= rq;
    char_code  <= cc;
    read_index <= ix;
    start      <= 1'b1;
    do @(posedge clk); while (busy);
    s = edit_line(rq, cc, ix);
    pending_status.push_back(fixed ? want : s);
    n_sent++;
    pace();
  endtask

  // mostly a small alphabet so delete-all finds runs of matches
  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 9) < 7) return CHAR_W'($urandom_range(8'h61, 8'h64));
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // grow the text to the top with random bytes, then push on the full buffer
  task automatic fill_to_top();
    issue(REQ_END, pick_char(), 8'($urandom));
    while (line_len < DEPTH - 1) issue(REQ_TYPE, CHAR_W'($urandom_range(0, 255)), 8'($urandom));
    issue(REQ_TYPE, pick_char(), 8'($urandom));
    issue(REQ_READ, pick_char(), IDX_W'(DEPTH - 2));
    issue(REQ_READ, pick_char(), 8'hFF);
    issue(REQ_HOME, pick_char(), 8'($urandom));
    issue(REQ_TYPE, pick_char(), 8'($urandom));
    issue(REQ_RIGHT, pick_char(), 8'($urandom));
    issue(REQ_BKSP, pick_char(), 8'($urandom));
    issue(REQ_DALL, pick_char(), 8'($urandom));
  endtask

  // one random request, weighted toward typing so the text gets long
  task automatic rand_request();
    int               r;
    logic [REQ_W-1:0] rq;
    logic [IDX_W-1:0] ix;
    r = $urandom_range(0, 199);
    if (r < 90)       rq = REQ_TYPE;
    else if (r < 110) rq = REQ_BKSP;
    else if (r < 120) rq = REQ_DALL;
    else if (r < 135) rq = REQ_LEFT;
    else if (r < 150) rq = REQ_RIGHT;
    else if (r < 156) rq = REQ_HOME;
    else if (r < 162) rq = REQ_END;
    else if (r < 192) rq = REQ_READ;
    else if (r < 198) rq = REQ_W'($urandom_range(9, 15));
    else              rq = REQ_CLEAR;
    // reads land mostly inside the text or just past its end
    if ($urandom_range(0, 4) != 0) ix = IDX_W'($urandom_range(0, line_len));
    else                           ix = IDX_W'($urandom_range(0, 255));
    issue(rq, pick_char(), ix);
  endtask

  // result checker: every strobe must match the oldest status owed
  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        $display("%0t: unexpected status, expected none actual len %0d cursor %0d",
                 $time, text_length, cursor_pos);
        mismatch_cnt++;
      end else begin
        want = pending_status.pop_front();
        check_field("read_char", want.rchar, read_char);
        check_field("cursor_pos", want.cpos, cursor_pos);
        check_field("text_length", want.len, text_length);
        check_field("refused", want.refused, refused);
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    row_t script[24];
    // edge cases on an empty buffer, adjacent copies, unused codes, clear
    script = '{
      '{REQ_READ,  8'h00, 8'h00, 1'b1, '{8'h00, 8'd0, 8'd0, 1'b0}},
      '{REQ_LEFT,  8'h00, 8'h00, 1'b1, '{8'h00, 8'd0, 8'd0, 1'b0}},
      '{REQ_RIGHT, 8'h00, 8'h00, 1'b1, '{8'h00, 8'd0, 8'd0, 1'b0}},
      '{REQ_BKSP,  8'h00, 8'h00, 1'b1, '{8'h00, 8'd0, 8'd0, 1'b0}},
      '{REQ_TYPE,  8'h00, 8'h00, 1'b1, '{8'h00, 8'd1, 8'd1, 1'b0}},
      '{REQ_TYPE,  8'hFF, 8'hFF, 1'b1, '{8'h00, 8'd2, 8'd2, 1'b0}},
      '{REQ_TYPE,  8'h61, 8'h00, 1'b1, '{8'h00, 8'd3, 8'd3, 1'b0}},
      '{REQ_HOME,  8'h00, 8'h00, 1'b1, '{8'h00, 8'd0, 8'd3, 1'b0}},
      '{REQ_TYPE,  8'h61, 8'h00, 1'b0, '0},
      '{REQ_RIGHT, 8'h00, 8'h00, 1'b0, '0},
      '{REQ_TYPE,  8'h61, 8'h00, 1'b0, '0},
      '{REQ_TYPE,  8'h61, 8'h00, 1'b0, '0},
      '{REQ_READ,  8'h00, 8'h00, 1'b0, '0},
      '{REQ_READ,  8'h00, 8'hFF, 1'b0, '0},
      '{REQ_LEFT,  8'h00, 8'h00, 1'b0, '0},
      '{REQ_DALL,  8'h61, 8'h00, 1'b0, '0},
      '{REQ_READ,  8'h00, 8'h01, 1'b0, '0},
      '{REQ_END,   8'h00, 8'h00, 1'b0, '0},
      '{REQ_DALL,  8'hFF, 8'h00, 1'b0, '0},
      '{4'hF,      8'hAA, 8'h55, 1'b0, '0},
      '{4'h9,      8'h55, 8'hAA, 1'b0, '0},
      '{REQ_TYPE,  8'h5A, 8'h00, 1'b0, '0},
      '{REQ_CLEAR, 8'h00, 8'h00, 1'b1, '{8'h00, 8'd0, 8'd0, 1'b0}},
      '{REQ_TYPE,  8'hA5, 8'h00, 1'b0, '0}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) issue(script[i].rq, script[i].cc, script[i].ix, script[i].fixed,
                              script[i].want);

    // one full-buffer pass up front, then mostly single requests
    fill_to_top();
    while (n_sent < N_REQUESTS) begin
      if ($urandom_range(0, 299) == 0) fill_to_top();
      else rand_request();
    end
    start <= 1'b0;

    // drain, then give a stray strobe a chance to show up
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
